FILE: rtl/ucm_pkg.sv
// ----------------------------------------------------------------------------
// Color table package
// Request, result and control types shared by the color table modules.
// ----------------------------------------------------------------------------
package ucm_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] read_index;
    } t_request;

    typedef struct packed {
        logic       found;
        logic [7:0] slot;
        logic [8:0] entry_count;
        logic       overflow;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic read_issue;
        logic scan_step;
        logic finish_hit;
        logic finish_miss;
        logic finish_read;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_dp_status;

endpackage

FILE: rtl/ucm_datapath.sv
// ----------------------------------------------------------------------------
// Color table datapath
// Table memory, count, overflow flag, scan pointer and result register.
// ----------------------------------------------------------------------------
module ucm_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ucm_pkg::t_request  i_request,
    input  ucm_pkg::t_ctrl_cmd i_cmd,
    output ucm_pkg::t_dp_status o_status,
    output ucm_pkg::t_result   o_result
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CNTW > 8) ? CNTW : 8;
    localparam int EXTW = (CNTW > 9) ? CNTW : 9;
    localparam logic [CNTW-1:0] FULL = CNTW'(TABLE_DEPTH);

    logic [23:0]     mem [TABLE_DEPTH];
    logic [23:0]     r_rdata;
    logic [23:0]     r_color;
    logic [7:0]      r_ridx;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_overflow, n_overflow;
    logic [CNTW-1:0] r_idx;
    logic [CNTW-1:0] r_pidx;
    logic            r_pend;
    ucm_pkg::t_result r_result, n_result;

    logic            w_idx_lt_cnt;
    logic            w_req_in_range;
    logic            w_ridx_in_range;
    logic            w_full;
    logic            w_wr_en;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    logic [EXTW-1:0] w_pidx_ext;
    logic [EXTW-1:0] w_count_ext;
    logic [EXTW-1:0] w_ncount_ext;

    assign w_full          = (r_count == FULL);
    assign w_idx_lt_cnt    = (r_idx < r_count);
    assign w_req_in_range  = (CMPW'(i_request.read_index) < CMPW'(r_count));
    assign w_ridx_in_range = (CMPW'(r_ridx) < CMPW'(r_count));

    assign w_wr_en   = i_cmd.finish_miss && !w_full;
    assign w_rd_en   = (i_cmd.read_issue && w_req_in_range) ||
                       (i_cmd.scan_step && w_idx_lt_cnt);
    assign w_rd_addr = i_cmd.read_issue ? AW'(i_request.read_index) : r_idx[AW-1:0];

    assign o_status.hit       = r_pend && (r_rdata == r_color);
    assign o_status.exhausted = !r_pend && !w_idx_lt_cnt;

    assign w_pidx_ext   = EXTW'(r_pidx);
    assign w_count_ext  = EXTW'(r_count);
    assign w_ncount_ext = EXTW'(n_count);

    // Table storage, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[AW-1:0]] <= r_color;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_color <= {i_request.red_in, i_request.green_in, i_request.blue_in};
            r_ridx  <= i_request.read_index;
        end
    end

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        if (i_cmd.finish_miss) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CNTW'(1);
            end
        end
    end

    always_comb begin
        n_result = r_result;
        if (i_cmd.finish_hit) begin
            n_result.found       = 1'b1;
            n_result.slot        = w_pidx_ext[7:0];
            n_result.entry_count = w_count_ext[8:0];
            n_result.overflow    = r_overflow;
            n_result.red_out     = 8'd0;
            n_result.green_out   = 8'd0;
            n_result.blue_out    = 8'd0;
        end else if (i_cmd.finish_miss) begin
            n_result.found       = 1'b0;
            n_result.slot        = w_full ? 8'd0 : w_count_ext[7:0];
            n_result.entry_count = w_ncount_ext[8:0];
            n_result.overflow    = n_overflow;
            n_result.red_out     = 8'd0;
            n_result.green_out   = 8'd0;
            n_result.blue_out    = 8'd0;
        end else if (i_cmd.finish_read) begin
            n_result.found       = 1'b0;
            n_result.slot        = r_ridx;
            n_result.entry_count = w_count_ext[8:0];
            n_result.overflow    = r_overflow;
            if (w_ridx_in_range) begin
                n_result.red_out   = r_rdata[23:16];
                n_result.green_out = r_rdata[15:8];
                n_result.blue_out  = r_rdata[7:0];
            end else begin
                n_result.red_out   = 8'd0;
                n_result.green_out = 8'd0;
                n_result.blue_out  = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_pend     <= 1'b0;
            r_idx      <= '0;
            r_result   <= '0;
        end else begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_result   <= n_result;
            if (i_cmd.accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= w_idx_lt_cnt;
                if (w_idx_lt_cnt) begin
                    r_idx <= r_idx + CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_pidx <= r_idx;
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/ucm_controller.sv
// ----------------------------------------------------------------------------
// Color table controller
// Sequences insert scans and table reads and raises the result strobe.
// ----------------------------------------------------------------------------
module ucm_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_op,
    input  ucm_pkg::t_dp_status i_status,
    output ucm_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    ucm_pkg::t_state r_state, n_state;
    logic            r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucm_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ucm_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == ucm_pkg::OP_READ) begin
                        o_cmd.read_issue = 1'b1;
                        n_state          = ucm_pkg::ST_READ;
                    end else begin
                        n_state = ucm_pkg::ST_SCAN;
                    end
                end
            end
            ucm_pkg::ST_SCAN: begin
                // The first matching slot ends the scan.
                if (i_status.hit) begin
                    o_cmd.finish_hit = 1'b1;
                    n_done           = 1'b1;
                    n_state          = ucm_pkg::ST_IDLE;
                end else if (i_status.exhausted) begin
                    o_cmd.finish_miss = 1'b1;
                    n_done            = 1'b1;
                    n_state           = ucm_pkg::ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ucm_pkg::ST_READ: begin
                o_cmd.finish_read = 1'b1;
                n_done            = 1'b1;
                n_state           = ucm_pkg::ST_IDLE;
            end
            default: begin
                n_state = ucm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ucm_pkg::ST_IDLE);
    assign o_done = r_done;

endmodule

FILE: rtl/unique_color_table_merge_top.sv
// ----------------------------------------------------------------------------
// Unique color table top level
// Deduplicating table of RGB colors with a linear search on insert.
// ----------------------------------------------------------------------------
// A read goes from ST_IDLE through ST_READ to the result strobe; an insert
// scans the stored colors in slot order from slot zero and ends at the first
// match or, for a new color, after the last stored entry.
// Throughput is one request at a time, set by the single read port of the
// table memory that the insert scan walks one entry per cycle.
// Synchronous active-low reset empties the table and clears the overflow flag;
// the receiver cannot stall, so each result strobe is high for one cycle only.
// ----------------------------------------------------------------------------
module unique_color_table_merge_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ucm_pkg::t_request i_request,
    output logic              o_done,
    output ucm_pkg::t_result  o_result
);

    // Command and status bundles between the controller and the datapath.
    ucm_pkg::t_ctrl_cmd  w_cmd;
    ucm_pkg::t_dp_status w_status;

    // The controller accepts a request whenever it is idle. A result strobe
    // and the next start can fall in the same cycle.
    ucm_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_request.op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // The datapath holds the table memory, the count, the sticky overflow
    // flag and the result register that drives o_result.
    ucm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_result  (o_result)
    );

endmodule

FILE: rtl/ucm_checker.sv
// ----------------------------------------------------------------------------
// Color table checker
// Port-level assertions on the request and result timing of the top level.
// ----------------------------------------------------------------------------
module ucm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_done,
    input ucm_pkg::t_result i_result
);

    // A result is only ever shown while the block is idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> !busy)
        else $error("result strobe while busy");

    // Every request passes through a busy state before its strobe, so strobes never touch.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |=> !i_done)
        else $error("back-to-back result strobes");

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // The overflow flag is sticky until reset.
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_result.overflow) |-> i_result.overflow)
        else $error("overflow flag cleared");

endmodule

bind unique_color_table_merge_top ucm_checker u_ucm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_done   (o_done),
    .i_result (o_result)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color table testbench
// Sends insert and read requests to the deduplicating color table, mirrors
// the table contents in a local copy to predict each result, and compares
// every result field against that prediction in request order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int SETTLE_TIME  = 300;
    localparam int RANDOM_ITEMS = 1750;

    // One request waiting in the backlog, with the idle cycles the sender
    // spends before offering it and a flag that makes the sender wait until
    // every outstanding result has arrived.
    typedef struct {
        ucm_pkg::t_request req;
        int unsigned       gap;
        bit                drain;
    } t_backlog_entry;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    ucm_pkg::t_request i_request = '0;
    logic              o_done;
    ucm_pkg::t_result  o_result;

    t_backlog_entry   request_backlog[$];
    ucm_pkg::t_result awaited_results[$];

    // Local copy of the table, used to predict every result.
    logic [23:0] palette_mirror [TABLE_DEPTH];
    int unsigned mirror_count    = 0;
    bit          mirror_overflow = 1'b0;

    // Colors already queued, tracked while the stimulus is built so that the
    // random read requests only address slots that will hold a color by then.
    logic [23:0] queued_colors[$];
    bit          queued_seen [logic [23:0]];

    int unsigned gap_left    = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    unique_color_table_merge_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the local table copy and return the result the
    // block must produce for it. An insert scans the stored colors in slot
    // order, so the first matching slot wins. A miss appends while there is
    // room; once the table is full a miss sets the sticky overflow flag and
    // reports slot zero with the count held at the table depth.
    function automatic ucm_pkg::t_result predict_result(ucm_pkg::t_request req);
        ucm_pkg::t_result res;
        logic [23:0]      color;
        bit               hit;
        res = '0;
        hit = 1'b0;
        if (req.op == ucm_pkg::OP_INSERT) begin
            color = {req.red_in, req.green_in, req.blue_in};
            for (int k = 0; k < mirror_count; k++) begin
                if (!hit && palette_mirror[k] == color) begin
                    hit      = 1'b1;
                    res.slot = 8'(k);
                end
            end
            if (hit) begin
                res.found = 1'b1;
            end else if (mirror_count < TABLE_DEPTH) begin
                palette_mirror[mirror_count] = color;
                res.slot                     = 8'(mirror_count);
                mirror_count                 = mirror_count + 1;
            end else begin
                mirror_overflow = 1'b1;
                res.slot        = 8'd0;
            end
        end else begin
            // A read echoes the index and returns the stored color only
            // below the count, and zeros at or past it.
            res.slot = req.read_index;
            if (req.read_index < mirror_count) begin
                {res.red_out, res.green_out, res.blue_out} = palette_mirror[req.read_index];
            end
        end
        res.entry_count = 9'(mirror_count);
        res.overflow    = mirror_overflow;
        return res;
    endfunction

    // Add a request to the backlog and keep track of which colors the table
    // will hold once it has been applied.
    task automatic queue_request(logic op, logic [23:0] color, logic [7:0] index,
                                 int unsigned gap, bit drain);
        t_backlog_entry entry;
        entry.req.op         = op;
        entry.req.red_in     = color[23:16];
        entry.req.green_in   = color[15:8];
        entry.req.blue_in    = color[7:0];
        entry.req.read_index = index;
        entry.gap            = gap;
        entry.drain          = drain;
        request_backlog.push_back(entry);
        if (op == ucm_pkg::OP_INSERT && !queued_seen.exists(color) &&
                queued_colors.size() < TABLE_DEPTH) begin
            queued_seen[color] = 1'b1;
            queued_colors.push_back(color);
        end
    endtask

    // Driver. A request is accepted at an edge where start is high and busy
    // is low. The prediction is taken at that same edge, so the local table
    // copy advances in exactly the order the block sees requests. With a
    // zero gap the next request follows at once and start simply stays high.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                awaited_results.push_back(predict_result(i_request));
                if (request_backlog.size() != 0 && request_backlog[0].gap == 0 &&
                        !request_backlog[0].drain) begin
                    i_request <= request_backlog[0].req;
                    request_backlog.delete(0);
                end else begin
                    start    <= 1'b0;
                    gap_left <= (request_backlog.size() != 0) ? request_backlog[0].gap : 0;
                end
            end else if (!start && request_backlog.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (!(request_backlog[0].drain && awaited_results.size() != 0)) begin
                    i_request <= request_backlog[0].req;
                    request_backlog.delete(0);
                    start     <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // Monitor. The receiver cannot stall, so every cycle with o_done high
    // carries one result that must match the oldest prediction.
    always @(posedge i_clk) begin
        ucm_pkg::t_result expected;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                error_count++;
            end else begin
                expected = awaited_results.pop_front();
                check_field("found",       expected.found,       o_result.found);
                check_field("slot",        expected.slot,        o_result.slot);
                check_field("entry_count", expected.entry_count, o_result.entry_count);
                check_field("overflow",    expected.overflow,    o_result.overflow);
                check_field("red_out",     expected.red_out,     o_result.red_out);
                check_field("green_out",   expected.green_out,   o_result.green_out);
                check_field("blue_out",    expected.blue_out,    o_result.blue_out);
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int unsigned pick;
        int unsigned gap;
        bit          calm;
        logic [23:0] color;

        // Directed requests: a read of the empty table, the extreme colors,
        // a repeat that must hit the first slot, hits on the newest slot,
        // colors one bit apart that the comparator must tell from each
        // other, and reads at both ends of the filled region and just past
        // it with noise on the unused color fields.
        queue_request(ucm_pkg::OP_READ,   24'h123456, 8'hFF, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h000000, 8'hFF, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'hFFFFFF, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h000000, 8'h00, 3, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'hFFFFFF, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'h000000, 8'h01, 0, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'h5A5A5A, 8'h02, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'hFF0000, 8'h00, 1, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h00FF00, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h0000FF, 8'h00, 2, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'hFFFFFF, 8'h00, 0, 1'b1);
        queue_request(ucm_pkg::OP_INSERT, 24'h0000FF, 8'hFF, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h000001, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h800000, 8'h00, 5, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'hAA55AA, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'h55AA55, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_INSERT, 24'hAA55AA, 8'h00, 0, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'hA5A5A5, 8'(queued_colors.size() - 1), 0, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'hFFFFFF, 8'h00, 11, 1'b0);
        queue_request(ucm_pkg::OP_READ,   24'h000000, 8'h07, 0, 1'b0);

        // Random requests. Repeats of stored colors exercise hits anywhere
        // in the scan, fresh colors fill the table and then overflow it, and
        // colors one bit away from a stored one stress the comparison.
        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gap  = calm ? 0 : $urandom_range(0, 11);
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                color = 24'($urandom);
                queue_request(ucm_pkg::OP_INSERT, color, 8'($urandom), gap, n % 250 == 0);
            end else if (pick < 68) begin
                color = queued_colors[$urandom_range(0, queued_colors.size() - 1)];
                queue_request(ucm_pkg::OP_INSERT, color, 8'($urandom), gap, 1'b0);
            end else if (pick < 75) begin
                color = queued_colors[$urandom_range(0, queued_colors.size() - 1)];
                color = color ^ (24'h1 << $urandom_range(0, 23));
                queue_request(ucm_pkg::OP_INSERT, color, 8'($urandom), gap, 1'b0);
            end else begin
                queue_request(ucm_pkg::OP_READ, 24'($urandom),
                              8'($urandom_range(0, queued_colors.size() - 1)), gap, 1'b0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || start || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_TIME) @(negedge i_clk);

        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog against a block that stops answering.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
